@@ rtl/core/rtcc_pkg.sv @@
// ----------------------------------------------------------------------------
// rtcc_pkg: shared constants and calendar tables
// Pipeline depth, time constants, reciprocal multipliers and month tables.
// ----------------------------------------------------------------------------
package rtcc_pkg;

    // Pipeline depth: one load enable per stage
    localparam int NSTAGE    = 11;
    // Stage at which the tick count and elapsed value are finished
    localparam int TICK_LAST = 4;

    typedef logic [NSTAGE-1:0] stage_vec_t;

    // Month correction masks, two bits per month index
    localparam logic [23:0] CORR_NORM = 24'h99AAA0;
    localparam logic [23:0] CORR_LEAP = 24'h445550;
    localparam logic [3:0]  MONTHS    = 4'd12;

    // Time constants
    localparam logic [16:0] SEC_PER_DAY   = 17'd86400;
    localparam logic [11:0] SEC_PER_HOUR  = 12'd3600;
    localparam logic [5:0]  SEC_PER_MIN   = 6'd60;
    localparam logic [6:0]  TICKS_PER_SEC = 7'd100;
    localparam logic [10:0] DAYS_PER_4YR  = 11'd1461;

    // Reciprocals: x/100 over 32 bits, (x>>7)/675, (x>>4)/225, (x>>2)/15
    localparam logic [31:0] RECIP_100 = 32'h51EB851F;
    localparam logic [19:0] RECIP_675 = 20'd795365;
    localparam logic [12:0] RECIP_225 = 13'd4661;
    localparam logic [10:0] RECIP_15  = 11'd1093;

    // Days before the given month index (0 is January), leap or normal year
    function automatic logic [8:0] cum_days(input logic [3:0] m1, input logic leap);
        logic [9:0]  half;
        logic [23:0] mask;
        logic [1:0]  corr;
        half = (10'(m1) * 10'd61 + 10'd1) >> 1;
        mask = leap ? CORR_LEAP : CORR_NORM;
        if (m1 < MONTHS)
        begin
            corr = mask[{m1, 1'b0} +: 2];
        end
        else
        begin
            corr = 2'd0;
        end
        return 9'(half - 10'(corr));
    endfunction

    // Month length; indices outside the year count as 31 days
    function automatic logic [4:0] month_len(input logic [3:0] m1, input logic leap);
        logic [4:0] len;
        unique case (m1)
            4'd1:                      len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // Reciprocal of a month length, scaled by 2^15
    function automatic logic [10:0] day_recip(input logic [4:0] len);
        logic [10:0] r;
        unique case (len)
            5'd28:   r = 11'd1171;
            5'd29:   r = 11'd1130;
            5'd30:   r = 11'd1093;
            default: r = 11'd1058;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/rtcc_ctrl.sv @@
// ----------------------------------------------------------------------------
// rtcc_ctrl: pipeline valid tracking
// Per-stage valid bits with bubble collapsing; issues load enables.
// ----------------------------------------------------------------------------
module rtcc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output rtcc_pkg::stage_vec_t ld
);
    import rtcc_pkg::*;

    stage_vec_t valid_reg;
    stage_vec_t valid_next;
    stage_vec_t rdy;
    stage_vec_t prev_valid;

    // A stage takes a request when it is empty or its content moves on
    always_comb
    begin
        rdy[NSTAGE-1] = !valid_reg[NSTAGE-1] || m_tready;
        for (int i = NSTAGE - 2; i >= 0; i--)
        begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
        prev_valid = {valid_reg[NSTAGE-2:0], s_tvalid};
        ld         = rdy & prev_valid;
        for (int i = 0; i < NSTAGE; i++)
        begin
            valid_next[i] = rdy[i] ? prev_valid[i] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = valid_reg[NSTAGE-1];

endmodule

@@ rtl/core/rtcc_ticks.sv @@
// ----------------------------------------------------------------------------
// rtcc_ticks: calendar to 100 Hz ticks
// Date to day count, seconds, ticks; holds the reference and gives elapsed.
// ----------------------------------------------------------------------------
module rtcc_ticks (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rtcc_pkg::stage_vec_t ld,
    input  logic                 func,
    input  logic [6:0]           year,
    input  logic [3:0]           month,
    input  logic [4:0]           day,
    input  logic [4:0]           hour,
    input  logic [5:0]           minute,
    input  logic [5:0]           second,
    output logic [31:0]          ticks,
    output logic [31:0]          elapsed
);
    import rtcc_pkg::*;

    logic        t1_func_reg;
    logic [6:0]  t1_year_reg;
    logic [3:0]  t1_m1_reg;
    logic [4:0]  t1_day_reg;
    logic [4:0]  t1_hour_reg;
    logic [5:0]  t1_min_reg;
    logic [5:0]  t1_sec_reg;
    logic        t2_func_reg;
    logic [31:0] t2_days_reg;
    logic [16:0] t2_sod_reg;
    logic        t3_func_reg;
    logic [31:0] t3_secs_reg;
    logic        t4_func_reg;
    logic [31:0] t4_now_reg;
    logic [31:0] ref_reg;
    logic [31:0] now_dly_reg     [NSTAGE-1:TICK_LAST];
    logic [31:0] elapsed_dly_reg [NSTAGE-1:TICK_LAST];

    logic [17:0] year_days;
    logic [15:0] base_days;
    logic [8:0]  month_days;
    logic [31:0] days;
    logic [16:0] sod;

    // Day count since 2000 and seconds of day
    always_comb
    begin
        year_days  = 18'(t1_year_reg) * 18'(DAYS_PER_4YR) + 18'd3;
        base_days  = year_days[17:2];
        month_days = cum_days(t1_m1_reg, t1_year_reg[1:0] == 2'b00);
        days       = 32'(base_days) + 32'(month_days) + 32'(t1_day_reg) - 32'd1;
        sod        = 17'(t1_hour_reg) * 17'(SEC_PER_HOUR)
                   + 17'(t1_min_reg) * 17'(SEC_PER_MIN) + 17'(t1_sec_reg);
    end

    always_ff @(posedge clk)
    begin
        // Stage 1: request fields
        if (ld[0])
        begin
            t1_func_reg <= func;
            t1_year_reg <= year;
            t1_m1_reg   <= month - 4'd1;
            t1_day_reg  <= day;
            t1_hour_reg <= hour;
            t1_min_reg  <= minute;
            t1_sec_reg  <= second;
        end
        // Stage 2: days and seconds of day
        if (ld[1])
        begin
            t2_func_reg <= t1_func_reg;
            t2_days_reg <= days;
            t2_sod_reg  <= sod;
        end
        // Stage 3: seconds since 2000
        if (ld[2])
        begin
            t3_func_reg <= t2_func_reg;
            t3_secs_reg <= t2_days_reg * 32'(SEC_PER_DAY) + 32'(t2_sod_reg);
        end
        // Stage 4: ticks
        if (ld[3])
        begin
            t4_func_reg <= t3_func_reg;
            t4_now_reg  <= t3_secs_reg * 32'(TICKS_PER_SEC);
        end
        // Stage 5: elapsed against the reference, then delay to the output
        if (ld[TICK_LAST])
        begin
            now_dly_reg[TICK_LAST]     <= t4_now_reg;
            elapsed_dly_reg[TICK_LAST] <= t4_func_reg ? 32'd0 : t4_now_reg - ref_reg;
        end
        for (int i = TICK_LAST + 1; i < NSTAGE; i++)
        begin
            if (ld[i])
            begin
                now_dly_reg[i]     <= now_dly_reg[i-1];
                elapsed_dly_reg[i] <= elapsed_dly_reg[i-1];
            end
        end
    end

    // Alarm requests set the new reference
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg <= 32'd0;
        end
        else if (ld[TICK_LAST] && t4_func_reg)
        begin
            ref_reg <= t4_now_reg;
        end
    end

    assign ticks   = now_dly_reg[NSTAGE-1];
    assign elapsed = elapsed_dly_reg[NSTAGE-1];

endmodule

@@ rtl/core/rtcc_alarm.sv @@
// ----------------------------------------------------------------------------
// rtcc_alarm: alarm time calculator
// Splits the timeout into days/hours/minutes/seconds, adds, carries, wraps.
// ----------------------------------------------------------------------------
module rtcc_alarm (
    input  logic                 clk,
    input  rtcc_pkg::stage_vec_t ld,
    input  logic                 func,
    input  logic [6:0]           year,
    input  logic [3:0]           month,
    input  logic [4:0]           day,
    input  logic [4:0]           hour,
    input  logic [5:0]           minute,
    input  logic [5:0]           second,
    input  logic [31:0]          timeout,
    output logic [6:0]           alarm_hundredths,
    output logic [5:0]           alarm_second,
    output logic [5:0]           alarm_minute,
    output logic [4:0]           alarm_hour,
    output logic [4:0]           alarm_day
);
    import rtcc_pkg::*;

    // Fields that ride along the pipeline
    typedef struct packed {
        logic       func;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [4:0] len;
        logic [6:0] hund;
    } alarm_ctx_t;

    alarm_ctx_t  c1_reg, c2_reg, c3_reg, c4_reg, c5_reg;
    alarm_ctx_t  c6_reg, c7_reg, c8_reg, c9_reg, c10_reg;
    logic [31:0] a1_timeout_reg;
    logic [25:0] a2_q_reg;
    logic [6:0]  a2_tlo_reg;
    logic [25:0] a3_q_reg;
    logic [8:0]  a3_d_reg, a4_d_reg, a5_d_reg, a6_d_reg, a7_d_reg;
    logic [16:0] a4_r_reg, a5_r_reg;
    logic [4:0]  a5_h_reg, a6_h_reg, a7_h_reg;
    logic [11:0] a6_rem_reg, a7_rem_reg;
    logic [5:0]  a7_mm_reg;
    logic [6:0]  a8_sec_reg, a8_min_reg;
    logic [5:0]  a8_hour_reg;
    logic [9:0]  a8_day_reg;
    logic [5:0]  a9_sec_reg, a9_min_reg;
    logic [4:0]  a9_hour_reg;
    logic [9:0]  a9_day_reg;
    logic [5:0]  a10_sec_reg, a10_min_reg;
    logic [4:0]  a10_hour_reg;
    logic [9:0]  a10_day_reg;
    logic [4:0]  a10_qd_reg;
    logic        a10_over_reg;
    logic [6:0]  out_hund_reg;
    logic [5:0]  out_sec_reg, out_min_reg;
    logic [4:0]  out_hour_reg, out_day_reg;

    alarm_ctx_t  ctx_in;
    alarm_ctx_t  ctx_hund;
    logic [3:0]  m1_in;
    logic [63:0] prod100;
    logic [38:0] prod675;
    logic [25:0] prod225;
    logic [20:0] prod15;
    logic [20:0] prod_day;
    logic [6:0]  hund;
    logic [5:0]  ss;
    logic [6:0]  min_c;
    logic [5:0]  hour_c;
    logic [1:0]  cs, cm, ch;
    logic [5:0]  sec_n, min_n;
    logic [4:0]  hour_n;
    logic [4:0]  day_n;
    logic [9:0]  day_rem;

    // Request context, month length from the calendar table
    always_comb
    begin
        m1_in         = month - 4'd1;
        ctx_in.func   = func;
        ctx_in.day    = day;
        ctx_in.hour   = hour;
        ctx_in.minute = minute;
        ctx_in.second = second;
        ctx_in.len    = (m1_in < MONTHS) ? month_len(m1_in, year[1:0] == 2'b00) : 5'd31;
        ctx_in.hund   = 7'd0;
    end

    // Reciprocal products and remainders
    always_comb
    begin
        prod100       = 64'(a1_timeout_reg) * 64'(RECIP_100);
        hund          = a2_tlo_reg - 7'(a2_q_reg[6:0] * TICKS_PER_SEC);
        ctx_hund      = c2_reg;
        ctx_hund.hund = hund;
        prod675       = 39'(a2_q_reg[25:7]) * 39'(RECIP_675);
        prod225       = 26'(a4_r_reg[16:4]) * 26'(RECIP_225);
        prod15        = 21'(a6_rem_reg[11:2]) * 21'(RECIP_15);
        ss            = 6'(a7_rem_reg - 12'(a7_mm_reg) * 12'(SEC_PER_MIN));
        prod_day      = 21'(a9_day_reg) * 21'(day_recip(c9_reg.len));
        day_rem       = a10_day_reg - 10'(a10_qd_reg) * 10'(c10_reg.len);
    end

    // Carry seconds into minutes, minutes into hours, hours into days
    always_comb
    begin
        if (a8_sec_reg >= 7'd120)
        begin
            sec_n = 6'(a8_sec_reg - 7'd120);
            cs    = 2'd2;
        end
        else if (a8_sec_reg >= 7'd60)
        begin
            sec_n = 6'(a8_sec_reg - 7'd60);
            cs    = 2'd1;
        end
        else
        begin
            sec_n = a8_sec_reg[5:0];
            cs    = 2'd0;
        end
        min_c = a8_min_reg + 7'(cs);
        if (min_c >= 7'd120)
        begin
            min_n = 6'(min_c - 7'd120);
            cm    = 2'd2;
        end
        else if (min_c >= 7'd60)
        begin
            min_n = 6'(min_c - 7'd60);
            cm    = 2'd1;
        end
        else
        begin
            min_n = min_c[5:0];
            cm    = 2'd0;
        end
        hour_c = a8_hour_reg + 6'(cm);
        if (hour_c >= 6'd48)
        begin
            hour_n = 5'(hour_c - 6'd48);
            ch     = 2'd2;
        end
        else if (hour_c >= 6'd24)
        begin
            hour_n = 5'(hour_c - 6'd24);
            ch     = 2'd1;
        end
        else
        begin
            hour_n = hour_c[4:0];
            ch     = 2'd0;
        end
        day_n = a10_over_reg ? day_rem[4:0] : a10_day_reg[4:0];
    end

    always_ff @(posedge clk)
    begin
        // Stage 1: request fields
        if (ld[0])
        begin
            c1_reg         <= ctx_in;
            a1_timeout_reg <= timeout;
        end
        // Stage 2: whole seconds of the timeout
        if (ld[1])
        begin
            c2_reg     <= c1_reg;
            a2_q_reg   <= prod100[62:37];
            a2_tlo_reg <= a1_timeout_reg[6:0];
        end
        // Stage 3: hundredths and whole days
        if (ld[2])
        begin
            c3_reg      <= ctx_hund;
            a3_q_reg    <= a2_q_reg;
            a3_d_reg    <= prod675[37:29];
        end
        // Stage 4: seconds left after the days
        if (ld[3])
        begin
            c4_reg   <= c3_reg;
            a4_d_reg <= a3_d_reg;
            a4_r_reg <= 17'(a3_q_reg - 26'(a3_d_reg) * 26'(SEC_PER_DAY));
        end
        // Stage 5: hours
        if (ld[4])
        begin
            c5_reg   <= c4_reg;
            a5_d_reg <= a4_d_reg;
            a5_r_reg <= a4_r_reg;
            a5_h_reg <= prod225[24:20];
        end
        // Stage 6: seconds left after the hours
        if (ld[5])
        begin
            c6_reg     <= c5_reg;
            a6_d_reg   <= a5_d_reg;
            a6_h_reg   <= a5_h_reg;
            a6_rem_reg <= 12'(a5_r_reg - 17'(a5_h_reg) * 17'(SEC_PER_HOUR));
        end
        // Stage 7: minutes
        if (ld[6])
        begin
            c7_reg     <= c6_reg;
            a7_d_reg   <= a6_d_reg;
            a7_h_reg   <= a6_h_reg;
            a7_rem_reg <= a6_rem_reg;
            a7_mm_reg  <= prod15[19:14];
        end
        // Stage 8: add the offset to the current time
        if (ld[7])
        begin
            c8_reg      <= c7_reg;
            a8_sec_reg  <= 7'(c7_reg.second) + 7'(ss);
            a8_min_reg  <= 7'(c7_reg.minute) + 7'(a7_mm_reg);
            a8_hour_reg <= 6'(c7_reg.hour) + 6'(a7_h_reg);
            a8_day_reg  <= 10'(c7_reg.day) + 10'(a7_d_reg);
        end
        // Stage 9: carries
        if (ld[8])
        begin
            c9_reg      <= c8_reg;
            a9_sec_reg  <= sec_n;
            a9_min_reg  <= min_n;
            a9_hour_reg <= hour_n;
            a9_day_reg  <= a8_day_reg + 10'(ch);
        end
        // Stage 10: day quotient by the month length
        if (ld[9])
        begin
            c10_reg      <= c9_reg;
            a10_sec_reg  <= a9_sec_reg;
            a10_min_reg  <= a9_min_reg;
            a10_hour_reg <= a9_hour_reg;
            a10_day_reg  <= a9_day_reg;
            a10_qd_reg   <= prod_day[19:15];
            a10_over_reg <= a9_day_reg > 10'(c9_reg.len);
        end
        // Stage 11: day wrap; query requests give zero alarm fields
        if (ld[10])
        begin
            out_hund_reg <= c10_reg.func ? c10_reg.hund : 7'd0;
            out_sec_reg  <= c10_reg.func ? a10_sec_reg  : 6'd0;
            out_min_reg  <= c10_reg.func ? a10_min_reg  : 6'd0;
            out_hour_reg <= c10_reg.func ? a10_hour_reg : 5'd0;
            out_day_reg  <= c10_reg.func ? day_n        : 5'd0;
        end
    end

    assign alarm_hundredths = out_hund_reg;
    assign alarm_second     = out_sec_reg;
    assign alarm_minute     = out_min_reg;
    assign alarm_hour       = out_hour_reg;
    assign alarm_day        = out_day_reg;

endmodule

@@ rtl/core/rtc_calendar_tick_and_alarm.sv @@
// A result leaves the last pipeline stage; while the output is not stalled,
// one request is taken per cycle. The 11-stage pipeline is set by the
// chain of reciprocal multiplies that splits the timeout into time units.
// Stages advance independently, so bubbles close up under output stalls.
// Reset (rst_n low, asynchronous) empties the pipeline and clears the
// stored tick reference to zero.
// ----------------------------------------------------------------------------
// rtc_calendar_tick_and_alarm: calendar ticks, elapsed time and alarm time
// Converts a calendar time to 100 Hz ticks since 2000, reports the time
// elapsed since the stored reference, and computes alarm time fields.
// ----------------------------------------------------------------------------
module rtc_calendar_tick_and_alarm (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // year[6:0] month[10:7] day[15:11] hour[20:16] minute[26:21]
    // second[32:27] timeout[64:33], zero fill [71:65]
    input  logic [71:0] s_tdata,
    // func[0]
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // ticks[31:0] elapsed[63:32] alarm_hundredths[70:64] alarm_second[76:71]
    // alarm_minute[82:77] alarm_hour[87:83] alarm_day[92:88], zero fill [95:93]
    output logic [95:0] m_tdata
);
    import rtcc_pkg::*;

    stage_vec_t  ld;
    logic        func;
    logic [6:0]  year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [31:0] timeout;
    logic [31:0] ticks;
    logic [31:0] elapsed;
    logic [6:0]  alarm_hundredths;
    logic [5:0]  alarm_second;
    logic [5:0]  alarm_minute;
    logic [4:0]  alarm_hour;
    logic [4:0]  alarm_day;

    // Request unpacking
    assign func    = s_tuser[0];
    assign year    = s_tdata[6:0];
    assign month   = s_tdata[10:7];
    assign day     = s_tdata[15:11];
    assign hour    = s_tdata[20:16];
    assign minute  = s_tdata[26:21];
    assign second  = s_tdata[32:27];
    assign timeout = s_tdata[64:33];

    rtcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ld       (ld)
    );

    rtcc_ticks u_ticks (
        .clk     (clk),
        .rst_n   (rst_n),
        .ld      (ld),
        .func    (func),
        .year    (year),
        .month   (month),
        .day     (day),
        .hour    (hour),
        .minute  (minute),
        .second  (second),
        .ticks   (ticks),
        .elapsed (elapsed)
    );

    rtcc_alarm u_alarm (
        .clk              (clk),
        .ld               (ld),
        .func             (func),
        .year             (year),
        .month            (month),
        .day              (day),
        .hour             (hour),
        .minute           (minute),
        .second           (second),
        .timeout          (timeout),
        .alarm_hundredths (alarm_hundredths),
        .alarm_second     (alarm_second),
        .alarm_minute     (alarm_minute),
        .alarm_hour       (alarm_hour),
        .alarm_day        (alarm_day)
    );

    // Result packing
    assign m_tdata = {3'b000, alarm_day, alarm_hour, alarm_minute, alarm_second,
                      alarm_hundredths, elapsed, ticks};

endmodule
